// ===== sv/shm_pkg.sv =====
// shm_pkg: shared constants and types of the sliding harmonic mean block
// depends on nothing; every other file uses it by scoped names
package shm_pkg;

    // window and fixed-point sizing
    localparam int MAX_WINDOW      = 64;
    localparam int RECIP_FRAC_BITS = 16;
    localparam int SLOT_W          = $clog2(MAX_WINDOW);
    localparam int WLEN_W          = 7;
    localparam int SAMPLE_W        = 16;
    localparam int MEAN_W          = 24;
    localparam int SCALE_W         = 10;
    localparam int MS_SCALE        = 1000;
    localparam int RECIP_W         = SCALE_W + RECIP_FRAC_BITS;
    localparam int SUM_W           = RECIP_W + SLOT_W;
    localparam int MEAN_SHIFT      = RECIP_FRAC_BITS + 8;
    localparam int NUM_W           = $clog2(MAX_WINDOW * MS_SCALE + 1) + MEAN_SHIFT;
    localparam int CNT_W           = $clog2(NUM_W + 1);
    localparam int WLEN_RESET      = 16;

    // 1000 * 2^frac, aligned to the top of the divider's dividend register
    localparam logic [NUM_W-1:0] RECIP_ONE_ALIGNED =
        NUM_W'(MS_SCALE) << (NUM_W - SCALE_W);
    localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

    // configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_WINDOW_LEN = 1'b0;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RECIP,
        ST_UPDATE,
        ST_LAUNCH,
        ST_MEAN,
        ST_DONE
    } t_state;

    // divider request and response
    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [SUM_W-1:0]  divisor;
        logic [CNT_W-1:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [RECIP_W-1:0] quotient;
        logic               ovf;
    } t_div_rsp;

    // configuration register view
    typedef struct packed {
        logic              clear;
        logic [WLEN_W-1:0] wlen;
    } t_cfg;

endpackage

// ===== sv/shm_in_if.sv =====
// shm_in_if: input channel carrying one delay sample per beat
// depends on shm_pkg for the field width
interface shm_in_if;
    logic                           valid;
    logic                           ready;
    logic [shm_pkg::SAMPLE_W-1:0]   sample_delay;

    modport source (output valid, output sample_delay, input ready);
    modport sink   (input valid, input sample_delay, output ready);
endinterface

// ===== sv/shm_out_if.sv =====
// shm_out_if: output channel carrying one harmonic mean per beat
// depends on shm_pkg for the field width
interface shm_out_if;
    logic                           valid;
    logic                           ready;
    logic [shm_pkg::MEAN_W-1:0]     mean_q8;

    modport source (output valid, output mean_q8, input ready);
    modport sink   (input valid, input mean_q8, output ready);
endinterface

// ===== sv/sliding_harmonic_mean.sv =====
// sliding_harmonic_mean: top level, sequencer around the reciprocal ring and divider
// depends on shm_pkg, shm_in_if, shm_out_if, shm_ring, shm_div and shm_cfg
//
// Usage
//   i_in carries one delay sample (ms) per beat, o_out one mean_q8 per beat.
//   The apb port holds window_len at byte address 0; a write to it clears the
//   window and should only be issued while no sample is in flight.
//   Samples are worked one at a time. A zero sample gives 0 through the
//   done state and the output register. A nonzero sample runs a 26-step
//   division for its reciprocal and a read-modify-write of the ring slot.
//   Once the window is full, a second 40-step division for the mean
//   follows. Both divisions use the one shared divider, which sets the pace.
//   The result sits in an output register; the next sample is taken while it
//   waits, and a stalled receiver only holds the block once a second result
//   is ready.
//   Reset (synchronous, active low) sets window_len to 16, empties the window
//   and drops o_out.valid. Ring contents need no clearing, as an entry is only
//   read back after the window has been refilled.
module sliding_harmonic_mean (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    shm_in_if.sink                        i_in,
    shm_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shm_pkg::PADDR_W-1:0]   paddr,
    input  logic [shm_pkg::PDATA_W-1:0]   pwdata,
    output logic [shm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    shm_pkg::t_state  r_state, n_state;
    shm_pkg::t_cfg    w_cfg;
    shm_pkg::t_div_req w_div_req;
    shm_pkg::t_div_rsp w_div_rsp;

    logic [shm_pkg::SAMPLE_W-1:0] r_sample;
    logic [shm_pkg::SLOT_W-1:0]   r_slot;
    logic [shm_pkg::WLEN_W-1:0]   r_fill;
    logic [shm_pkg::SUM_W-1:0]    r_sum;
    logic [shm_pkg::RECIP_W-1:0]  r_recip;
    logic [shm_pkg::MEAN_W-1:0]   r_res;
    logic                         r_out_valid;
    logic [shm_pkg::MEAN_W-1:0]   r_out_data;

    logic                          w_accept;
    logic                          w_load_out;
    logic                          w_full;
    logic                          w_fill_done;
    logic [shm_pkg::SLOT_W-1:0]    w_slot;
    logic [shm_pkg::WLEN_W-1:0]    w_slot_inc;
    logic [shm_pkg::WLEN_W-1:0]    w_fill_next;
    logic [shm_pkg::SUM_W-1:0]     w_sum_next;
    logic [shm_pkg::RECIP_W-1:0]   w_old;
    logic [shm_pkg::WLEN_W+shm_pkg::SCALE_W-1:0] w_scaled;
    logic [shm_pkg::NUM_W-1:0]     w_num;
    logic                          w_mem_re;
    logic                          w_mem_we;
    logic                          w_sat;

    // configuration register
    shm_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // reciprocal ring
    shm_ring u_ring (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_slot),
        .i_wdata (r_recip),
        .i_re    (w_mem_re),
        .i_raddr (w_slot),
        .o_rdata (w_old)
    );

    // shared divider
    shm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    // slot, fill and running sum arithmetic
    always_comb begin
        w_slot      = ({1'b0, r_slot} >= w_cfg.wlen) ? '0 : r_slot;
        w_slot_inc  = shm_pkg::WLEN_W'(w_slot) + 1'b1;
        w_full      = r_fill >= w_cfg.wlen;
        w_fill_next = w_full ? r_fill : r_fill + 1'b1;
        w_fill_done = w_fill_next >= w_cfg.wlen;
        w_sum_next  = r_sum - (w_full ? shm_pkg::SUM_W'(w_old) : '0)
                      + shm_pkg::SUM_W'(r_recip);
        w_scaled    = w_cfg.wlen * shm_pkg::SCALE_W'(shm_pkg::MS_SCALE);
        w_num       = shm_pkg::NUM_W'(w_scaled) << shm_pkg::MEAN_SHIFT;
        w_sat       = w_div_rsp.ovf ||
                      (w_div_rsp.quotient > shm_pkg::RECIP_W'(shm_pkg::MEAN_MAX));
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            shm_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = (i_in.sample_delay == '0) ? shm_pkg::ST_DONE
                                                        : shm_pkg::ST_RECIP;
                end
            end
            shm_pkg::ST_RECIP: begin
                if (w_div_rsp.done) begin
                    n_state = shm_pkg::ST_UPDATE;
                end
            end
            shm_pkg::ST_UPDATE: begin
                n_state = w_fill_done ? shm_pkg::ST_LAUNCH : shm_pkg::ST_DONE;
            end
            shm_pkg::ST_LAUNCH: begin
                n_state = shm_pkg::ST_MEAN;
            end
            shm_pkg::ST_MEAN: begin
                if (w_div_rsp.done) begin
                    n_state = shm_pkg::ST_DONE;
                end
            end
            shm_pkg::ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_state = shm_pkg::ST_IDLE;
                end
            end
            default: n_state = shm_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_in.ready         = 1'b0;
        w_mem_re           = 1'b0;
        w_mem_we           = 1'b0;
        w_load_out         = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = shm_pkg::RECIP_ONE_ALIGNED;
        w_div_req.divisor  = shm_pkg::SUM_W'(i_in.sample_delay);
        w_div_req.steps    = shm_pkg::CNT_W'(shm_pkg::RECIP_W);
        unique case (r_state)
            shm_pkg::ST_IDLE: begin
                i_in.ready      = 1'b1;
                w_mem_re        = i_in.valid;
                w_div_req.start = i_in.valid && (i_in.sample_delay != '0);
            end
            shm_pkg::ST_UPDATE: begin
                w_mem_we = 1'b1;
            end
            shm_pkg::ST_LAUNCH: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_num;
                w_div_req.divisor  = r_sum;
                w_div_req.steps    = shm_pkg::CNT_W'(shm_pkg::NUM_W);
            end
            shm_pkg::ST_DONE: begin
                w_load_out = !r_out_valid || o_out.ready;
            end
            default: begin
            end
        endcase
    end

    assign w_accept = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= shm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window state: sum, fill count and write slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg.clear) begin
            r_sum  <= '0;
            r_fill <= '0;
            r_slot <= '0;
        end else if (r_state == shm_pkg::ST_UPDATE) begin
            r_sum  <= w_sum_next;
            r_fill <= w_fill_next;
            r_slot <= (w_slot_inc >= w_cfg.wlen) ? '0
                                                 : w_slot_inc[shm_pkg::SLOT_W-1:0];
        end
    end

    // per-sample working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sample <= i_in.sample_delay;
            r_res    <= '0;
        end
        if (r_state == shm_pkg::ST_RECIP && w_div_rsp.done) begin
            r_recip <= w_div_rsp.quotient;
        end
        if (r_state == shm_pkg::ST_UPDATE) begin
            r_res <= shm_pkg::MEAN_W'(r_sample);
        end
        if (r_state == shm_pkg::ST_MEAN && w_div_rsp.done) begin
            r_res <= w_sat ? shm_pkg::MEAN_MAX
                           : w_div_rsp.quotient[shm_pkg::MEAN_W-1:0];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_data <= r_res;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.mean_q8 = r_out_data;

endmodule

// ===== sv/shm_ring.sv =====
// shm_ring: ring of stored reciprocals, one write and one registered read port
// depends on shm_pkg for depth and width
module shm_ring (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [shm_pkg::SLOT_W-1:0]    i_waddr,
    input  logic [shm_pkg::RECIP_W-1:0]   i_wdata,
    input  logic                          i_re,
    input  logic [shm_pkg::SLOT_W-1:0]    i_raddr,
    output logic [shm_pkg::RECIP_W-1:0]   o_rdata
);

    logic [shm_pkg::RECIP_W-1:0] r_mem [shm_pkg::MAX_WINDOW];
    logic [shm_pkg::RECIP_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/shm_div.sv =====
// shm_div: restoring divider, one quotient bit per cycle, shared by both divisions
// depends on shm_pkg for widths and the request/response structs
module shm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  shm_pkg::t_div_req   i_req,
    output shm_pkg::t_div_rsp   o_rsp
);

    logic [shm_pkg::CNT_W-1:0]   r_cnt;
    logic                        r_done;
    logic [shm_pkg::SUM_W-1:0]   r_rem;
    logic [shm_pkg::NUM_W-1:0]   r_dvd;
    logic [shm_pkg::SUM_W-1:0]   r_dvs;
    logic [shm_pkg::RECIP_W-1:0] r_q;
    logic                        r_ovf;

    logic [shm_pkg::SUM_W:0]     w_trial;
    logic [shm_pkg::SUM_W:0]     w_diff;
    logic                        w_ge;

    // one trial subtraction per step
    always_comb begin
        w_trial = {r_rem, r_dvd[shm_pkg::NUM_W-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_diff  = w_trial - {1'b0, r_dvs};
    end

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == shm_pkg::CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder, dividend and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_q   <= '0;
            r_ovf <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[shm_pkg::SUM_W-1:0] : w_trial[shm_pkg::SUM_W-1:0];
            r_dvd <= r_dvd << 1;
            r_q   <= {r_q[shm_pkg::RECIP_W-2:0], w_ge};
            r_ovf <= r_ovf | r_q[shm_pkg::RECIP_W-1];
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;
    assign o_rsp.ovf      = r_ovf;

endmodule

// ===== sv/shm_cfg.sv =====
// shm_cfg: apb register holding the window length, write clears the window
// depends on shm_pkg for address layout and the t_cfg struct
module shm_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [shm_pkg::PADDR_W-1:0]   paddr,
    input  logic [shm_pkg::PDATA_W-1:0]   pwdata,
    output logic [shm_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output shm_pkg::t_cfg                 o_cfg
);

    logic [shm_pkg::WLEN_W-1:0] r_wlen;
    logic [shm_pkg::WLEN_W-1:0] w_raw;
    logic [shm_pkg::WLEN_W-1:0] w_clamped;
    logic                       w_wr;

    // write strobe and clamp of the written length
    always_comb begin
        w_wr  = psel && penable && pwrite && pready &&
                (paddr[2] == shm_pkg::REG_WINDOW_LEN);
        w_raw = pwdata[shm_pkg::WLEN_W-1:0];
        if (w_raw < shm_pkg::WLEN_W'(2)) begin
            w_clamped = shm_pkg::WLEN_W'(2);
        end else if (32'(w_raw) > shm_pkg::MAX_WINDOW) begin
            w_clamped = shm_pkg::WLEN_W'(shm_pkg::MAX_WINDOW);
        end else begin
            w_clamped = w_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= shm_pkg::WLEN_W'(shm_pkg::WLEN_RESET);
        end else if (w_wr) begin
            r_wlen <= w_clamped;
        end
    end

    // read mux
    always_comb begin
        unique case (paddr[2])
            shm_pkg::REG_WINDOW_LEN: prdata = shm_pkg::PDATA_W'(r_wlen);
            default:                 prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign o_cfg.clear = w_wr;
    assign o_cfg.wlen  = r_wlen;

endmodule

// ===== sv/sliding_harmonic_mean_chk.sv =====
// sliding_harmonic_mean_chk: port-level checks of the top level, attached by bind
// depends on shm_pkg for field widths
module sliding_harmonic_mean_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [shm_pkg::MEAN_W-1:0]    i_out_mean
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // a stalled result beat holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_mean))
        else $error("stalled result beat changed");

    // one sample in flight: input closes right after a beat is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while a sample is in flight");

    // a fresh result only appears after the input was closed for the sample
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without sample work");

endmodule

bind sliding_harmonic_mean sliding_harmonic_mean_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mean  (o_out.mean_q8)
);

// ===== verif/sliding_harmonic_mean_tb.sv =====
// sliding_harmonic_mean_tb: self-checking bench for the sliding harmonic mean block
// depends on shm_pkg, shm_in_if, shm_out_if and the sliding_harmonic_mean rtl
// drives delay beats and apb writes, predicts each mean_q8 and checks it in order
module sliding_harmonic_mean_tb;

    localparam longint unsigned RECIP_UNIT   =
        64'(shm_pkg::MS_SCALE) << shm_pkg::RECIP_FRAC_BITS;
    localparam int              IDLE_PCT     = 14;
    localparam int              SETTLE_CYC   = 12;
    localparam int              LONG_HOLD    = 500;
    localparam int              NUM_PHASES   = 12;
    localparam int              PHASE_BEATS  = 150;
    localparam logic [shm_pkg::PADDR_W-1:0] ADDR_WINDOW_LEN =
        {shm_pkg::REG_WINDOW_LEN, 2'b00};
    localparam logic [shm_pkg::PADDR_W-1:0] ADDR_SPARE      =
        {~shm_pkg::REG_WINDOW_LEN, 2'b00};

    // window tracker and queue of expected means
    class t_mean_scoreboard;
        logic [shm_pkg::RECIP_W-1:0] recip_ring [shm_pkg::MAX_WINDOW];
        longint unsigned             recip_total;
        int unsigned                 fill_cnt;
        int unsigned                 next_slot;
        int unsigned                 win_len;
        logic [shm_pkg::MEAN_W-1:0]  expected_means [$];
        int unsigned                 fail_count;

        function new();
            win_len    = shm_pkg::WLEN_RESET;
            fail_count = 0;
            clear_window();
        endfunction

        function void clear_window();
            recip_total = 0;
            fill_cnt    = 0;
            next_slot   = 0;
        endfunction

        // append one expected mean at the tail
        function void queue_mean(logic [shm_pkg::MEAN_W-1:0] mean);
            expected_means = {expected_means, mean};
        endfunction

        // register write as seen at the access beat
        function void write_reg(logic [shm_pkg::PADDR_W-1:0] addr,
                                logic [shm_pkg::PDATA_W-1:0] data);
            int unsigned len;
            if (addr != ADDR_WINDOW_LEN)
                return;
            len = 32'(data[shm_pkg::WLEN_W-1:0]);
            if (len < 2)
                len = 2;
            if (len > shm_pkg::MAX_WINDOW)
                len = shm_pkg::MAX_WINDOW;
            win_len = len;
            clear_window();
        endfunction

        // one accepted delay beat gives one expected mean
        function void note_delay(logic [shm_pkg::SAMPLE_W-1:0] delay);
            longint unsigned recip;
            longint unsigned quot;
            int unsigned     slot;
            if (delay == 0) begin
                queue_mean('0);
                return;
            end
            recip = RECIP_UNIT / delay;
            slot  = (next_slot >= win_len) ? 0 : next_slot;
            if (fill_cnt >= win_len)
                recip_total -= recip_ring[slot];
            else
                fill_cnt++;
            recip_ring[slot] = recip[shm_pkg::RECIP_W-1:0];
            recip_total += recip;
            slot++;
            next_slot = (slot >= win_len) ? 0 : slot;
            if (fill_cnt < win_len) begin
                queue_mean(shm_pkg::MEAN_W'(delay));
                return;
            end
            if (recip_total == 0) begin
                quot = 64'(shm_pkg::MEAN_MAX);
            end else begin
                quot = (longint'(win_len) * RECIP_UNIT * 256) / recip_total;
                if (quot > shm_pkg::MEAN_MAX)
                    quot = 64'(shm_pkg::MEAN_MAX);
            end
            queue_mean(quot[shm_pkg::MEAN_W-1:0]);
        endfunction

        function void check_mean(logic [shm_pkg::MEAN_W-1:0] actual);
            logic [shm_pkg::MEAN_W-1:0] want;
            if (expected_means.size() == 0) begin
                $error("mean_q8: unexpected beat, actual %0d", actual);
                fail_count++;
                return;
            end
            want = expected_means[0];
            expected_means.delete(0);
            if (actual !== want) begin
                $error("mean_q8 mismatch: expected %0d, actual %0d", want, actual);
                fail_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_means.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [shm_pkg::PADDR_W-1:0]  paddr;
    logic [shm_pkg::PDATA_W-1:0]  pwdata;
    logic [shm_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    shm_in_if  in_if ();
    shm_out_if out_if ();

    t_mean_scoreboard sb;
    bit          steady;
    bit          hold_off_req;
    int unsigned hold_left;

    sliding_harmonic_mean DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // run limit
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // accepted beats on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && in_if.valid && in_if.ready)
            sb.note_delay(in_if.sample_delay);
        if (i_rst_n && out_if.valid && out_if.ready)
            sb.check_mean(out_if.mean_q8);
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_if.ready <= 1'b0;
        end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = LONG_HOLD;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic offer_delay(input logic [shm_pkg::SAMPLE_W-1:0] delay);
        @(negedge i_clk);
        in_if.valid        <= 1'b1;
        in_if.sample_delay <= delay;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
    endtask

    task automatic random_gaps();
        if (!steady)
            while ($urandom_range(0, 99) < IDLE_PCT)
                idle_input();
    endtask

    // hold the input until every expected mean has come back
    task automatic wait_drain();
        idle_input();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [shm_pkg::PADDR_W-1:0] addr,
                             input logic [shm_pkg::PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(addr, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly a jittered link delay, some zeros, extremes and full-range noise
    function automatic logic [shm_pkg::SAMPLE_W-1:0] next_delay(int unsigned centre,
                                                                int unsigned spread);
        int unsigned pick;
        int unsigned v;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10) begin
            case ($urandom_range(0, 3))
                0:       return 16'd1;
                1:       return 16'hFFFF;
                2:       return 16'h8000;
                default: return 16'd2;
            endcase
        end
        if (pick < 25)
            return shm_pkg::SAMPLE_W'($urandom);
        v = centre + $urandom_range(0, spread);
        if (v > 65535)
            v = 65535;
        return shm_pkg::SAMPLE_W'(v);
    endfunction

    initial begin
        logic [shm_pkg::SAMPLE_W-1:0] reset_beats [3];
        logic [shm_pkg::SAMPLE_W-1:0] short_beats [13];
        logic [shm_pkg::PDATA_W-1:0]  window_writes [9];
        logic [shm_pkg::PDATA_W-1:0]  wval;
        int unsigned                  centre;
        int unsigned                  spread;

        reset_beats   = '{16'd0, 16'hFFFF, 16'd1};
        short_beats   = '{16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd1, 16'd1,
                          16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF, 16'd0, 16'd2};
        window_writes = '{32'd0, 32'd64, 32'd1, 32'd127, 32'd65, 32'd3,
                          32'hFFFF_FF80, 32'd2, 32'd33};

        sb                 = new();
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_if.valid        = 1'b0;
        in_if.sample_delay = '0;
        out_if.ready       = 1'b0;
        steady             = 1'b0;
        hold_off_req       = 1'b0;
        hold_left          = 0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: zero, extremes and a partial fill at the reset window length
        foreach (reset_beats[k])
            offer_delay(reset_beats[k]);
        wait_drain();

        // directed: clamped short window, saturation and bit patterns
        apb_write(ADDR_WINDOW_LEN, 32'd0);
        foreach (short_beats[k])
            offer_delay(short_beats[k]);

        // random phases, each behind a window length write
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drain();
            steady = (p == 2);
            wval   = (p < 9) ? window_writes[p] : shm_pkg::PDATA_W'($urandom);
            apb_write(ADDR_WINDOW_LEN, wval);
            centre = $urandom_range(1, 1 << $urandom_range(0, 15));
            spread = centre / 4 + 1;
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if (p == 3 && n == 40)
                    hold_off_req = 1'b1;
                // pause until drained, then poke the unused address mid-window
                if (p == 6 && n == PHASE_BEATS / 2) begin
                    wait_drain();
                    apb_write(ADDR_SPARE, shm_pkg::PDATA_W'($urandom));
                end
                random_gaps();
                offer_delay(next_delay(centre, spread));
            end
        end

        wait_drain();
        repeat (100) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("mean_q8: %0d expected beats never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
